// File: hdl/ndkj_pkg.sv
// ----------------------------------------------------------------------------
// ndkj_pkg
// Shared types and constants for the nearest-date keyed join.
// ----------------------------------------------------------------------------
package ndkj_pkg;

  localparam int unsigned REF_ROWS_DEF = 1024;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned DATE_W    = 32;
  localparam int unsigned WIN_W     = 31;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned REF_IDX_W = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BEFORE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_AFTER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_UNMATCHED = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [KEY_W-1:0]         key;
    logic signed [DATE_W-1:0] date;
  } join_in_t;

  typedef struct packed {
    logic                     matched;
    logic [KEY_W-1:0]         out_key;
    logic signed [DATE_W-1:0] query_date;
    logic signed [DATE_W-1:0] ref_date;
    logic [DATE_W-1:0]        date_gap;
    logic [31:0]              query_index;
    logic [REF_IDX_W-1:0]     ref_index;
  } join_out_t;

endpackage

// File: hdl/nearest_date_keyed_join.sv
// ----------------------------------------------------------------------------
// nearest_date_keyed_join
// Keyed interval join: each query picks the loaded row with equal key and the
// nearest date inside the configured window, earliest row on ties.
//
// Usage:
//   Commands enter on in_i when start is high and busy is low.
//   Clear and load complete in the accept cycle; busy stays low.
//   A query raises busy and scans the table, one RAM read per cycle, through
//   a two-stage compare pipeline; the scan reads the rows in order over the
//   table RAM's single read port.
//   The result appears on res_o for one cycle with res_valid_o high, in the
//   last busy cycle. Inner mode drops unmatched queries; left mode reports
//   them with matched low and zero reference fields.
//   The receiver cannot stall: each result is taken in its strobe cycle.
//   Configuration writes go through cfg_valid_i/cfg_ready_o, always ready,
//   and must be issued only while idle; the block does not enforce this.
//   Reset empties the table and clears counters and control registers; table
//   contents are undefined until loaded and never read before that.
// ----------------------------------------------------------------------------
module nearest_date_keyed_join
  import ndkj_pkg::*;
#(
  parameter int unsigned REF_ROWS = REF_ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  join_in_t             in_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                 res_valid_o,
  output join_out_t            res_o
);

  localparam int unsigned AW    = (REF_ROWS > 1) ? $clog2(REF_ROWS) : 1;
  localparam int unsigned CW    = $clog2(REF_ROWS + 1);
  localparam int unsigned ROW_W = KEY_W + DATE_W;
  localparam int unsigned WIDE  = DATE_W + 2;

  state_e state_q, state_d;

  logic [CW-1:0]   ref_count_q;
  logic [31:0]     query_count_q;
  logic [WIN_W-1:0] wb_q, wa_q;
  logic            keep_q;

  logic [KEY_W-1:0]         q_key_q;
  logic signed [DATE_W-1:0] q_date_q;
  logic signed [WIDE-1:0]   lo_q, hi_q;
  logic [31:0]              qidx_q;

  logic [AW-1:0] addr_q;
  logic          p1_valid_q;
  logic [AW-1:0] p1_idx_q;
  logic          p2_valid_q, p2_hit_q;
  logic [DATE_W-1:0]        p2_gap_q;
  logic signed [DATE_W-1:0] p2_date_q;
  logic [AW-1:0]            p2_idx_q;

  logic                     found_q;
  logic [DATE_W-1:0]        best_gap_q;
  logic signed [DATE_W-1:0] best_date_q;
  logic [AW-1:0]            best_idx_q;

  logic accept, q_accept, ld_accept, clr_accept, last_addr, scan_run, take_best;
  logic ram_we;
  logic [ROW_W-1:0] ram_rdata;

  logic [KEY_W-1:0]         r_key;
  logic signed [DATE_W-1:0] r_date;
  logic signed [WIDE-1:0]   r_wide, q_wide_in;
  logic signed [DATE_W:0]   diff;
  logic [DATE_W:0]          diff_neg;
  logic                     s1_hit;
  logic [DATE_W-1:0]        s1_gap;

  assign accept     = start && !busy;
  assign q_accept   = accept && (in_i.cmd == CMD_QUERY);
  assign ld_accept  = accept && (in_i.cmd == CMD_LOAD);
  assign clr_accept = accept && (in_i.cmd == CMD_CLEAR);
  assign ram_we     = ld_accept && (ref_count_q < CW'(REF_ROWS));
  assign last_addr  = (CW'(addr_q) == (ref_count_q - CW'(1)));
  assign cfg_ready_o = 1'b1;

  ndkj_ram #(
    .WIDTH (ROW_W),
    .DEPTH (REF_ROWS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ref_count_q[AW-1:0]),
    .wdata_i ({in_i.key, in_i.date}),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // compare stage on RAM read data
  assign r_key     = ram_rdata[ROW_W-1:DATE_W];
  assign r_date    = $signed(ram_rdata[DATE_W-1:0]);
  assign r_wide    = WIDE'(r_date);
  assign q_wide_in = WIDE'(in_i.date);
  assign diff      = (DATE_W + 1)'(q_date_q) - (DATE_W + 1)'(r_date);
  assign diff_neg  = -diff;
  assign s1_gap    = diff[DATE_W] ? diff_neg[DATE_W-1:0] : diff[DATE_W-1:0];
  assign s1_hit    = (r_key == q_key_q) && (r_wide >= lo_q) && (r_wide <= hi_q);

  assign take_best = p2_valid_q && p2_hit_q && (!found_q || (p2_gap_q < best_gap_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_accept) begin
          state_d = (ref_count_q == '0) ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_addr) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!p1_valid_q && !p2_valid_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state_q != ST_IDLE);
    scan_run    = (state_q == ST_SCAN);
    res_valid_o = (state_q == ST_DONE) && (found_q || keep_q);
    res_o.matched     = found_q;
    res_o.out_key     = q_key_q;
    res_o.query_date  = q_date_q;
    res_o.ref_date    = found_q ? best_date_q : '0;
    res_o.date_gap    = found_q ? best_gap_q : '0;
    res_o.query_index = qidx_q;
    res_o.ref_index   = found_q ? REF_IDX_W'(best_idx_q) : '0;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ref_count_q   <= '0;
      query_count_q <= '0;
      wb_q          <= '0;
      wa_q          <= '0;
      keep_q        <= 1'b0;
      addr_q        <= '0;
      p1_valid_q    <= 1'b0;
      p2_valid_q    <= 1'b0;
      found_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      p1_valid_q <= scan_run;
      p2_valid_q <= p1_valid_q;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WINDOW_BEFORE:  wb_q   <= cfg_data_i[WIN_W-1:0];
          CFG_WINDOW_AFTER:   wa_q   <= cfg_data_i[WIN_W-1:0];
          CFG_KEEP_UNMATCHED: keep_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (clr_accept) begin
        ref_count_q   <= '0;
        query_count_q <= '0;
      end
      if (ram_we) begin
        ref_count_q <= ref_count_q + CW'(1);
      end
      if (q_accept) begin
        query_count_q <= query_count_q + 32'd1;
        addr_q        <= '0;
        found_q       <= 1'b0;
      end else if (scan_run) begin
        addr_q <= addr_q + AW'(1);
      end
      if (take_best) begin
        found_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (q_accept) begin
      q_key_q  <= in_i.key;
      q_date_q <= in_i.date;
      lo_q     <= q_wide_in - $signed(WIDE'(wb_q));
      hi_q     <= q_wide_in + $signed(WIDE'(wa_q));
      qidx_q   <= query_count_q;
    end
    p1_idx_q  <= addr_q;
    p2_hit_q  <= s1_hit;
    p2_gap_q  <= s1_gap;
    p2_date_q <= r_date;
    p2_idx_q  <= p1_idx_q;
    if (take_best) begin
      best_gap_q  <= p2_gap_q;
      best_date_q <= p2_date_q;
      best_idx_q  <= p2_idx_q;
    end
  end

  a_res_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result strobe outside a query");

  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.cmd == CMD_QUERY)) |=> busy)
    else $error("query accepted without raising busy");

  a_best_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && found_q) |-> (CW'(best_idx_q) < ref_count_q))
    else $error("chosen row beyond loaded rows");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CW'(addr_q) < ref_count_q))
    else $error("scan address beyond loaded rows");

endmodule

// File: hdl/ndkj_ram.sv
// ----------------------------------------------------------------------------
// ndkj_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ndkj_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
